// ===== design/box_blur_3x3_edge_aware_macros.svh =====
// assertion macros shared by the box blur design files
`ifndef BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`ifndef ASSERT_OFF
`define BB3_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define BB3_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BB3_ASSERT(lbl, clk, rstn, prop, msg)
`define BB3_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== design/bb3_pkg.sv =====
// types, constants and tables shared by the box blur modules
package bb3_pkg;

    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int SUM_W     = 12;
    localparam int X_W       = 13;
    localparam int D_W       = 5;
    localparam int M_W       = 16;
    localparam int Q0_W      = 9;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd768;

    // which pending pixel a result belongs to, relative to the input at (r, c)
    typedef enum logic [1:0] {
        KIND_UP_LEFT,   // (r-1, c-1)
        KIND_UP,        // (r-1, c), last column
        KIND_LEFT,      // (r, c-1), last row
        KIND_HERE       // (r, c), last row and column
    } bb3_kind_t;

    typedef struct packed {
        logic      take;
        logic      update;
        bb3_kind_t sel;
        logic      load;
        logic      last;
    } bb3_cmd_t;

    typedef struct packed {
        logic [3:0] pend;
        logic       out_free;
    } bb3_stat_t;

    // floor(2^16 / (2n)) for neighbor count n
    function automatic logic [M_W-1:0] bb3_recip(input logic [3:0] n);
        logic [M_W-1:0] m;
        unique case (n)
            4'd2:    m = 16'd16384;
            4'd3:    m = 16'd10922;
            4'd4:    m = 16'd8192;
            4'd6:    m = 16'd5461;
            4'd9:    m = 16'd3640;
            default: m = 16'd32768;
        endcase
        return m;
    endfunction

endpackage

// ===== design/bb3_ctrl.sv =====
// controller: sequences accept, line store update and one result at a time
`include "box_blur_3x3_edge_aware_macros.svh"
module bb3_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output bb3_pkg::bb3_cmd_t cmd,
    input  bb3_pkg::bb3_stat_t stat
);
    import bb3_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SUM,
        ST_MUL,
        ST_LOAD
    } state_t;

    state_t     state_reg;
    logic [3:0] pend_reg;
    bb3_kind_t  sel_reg;
    logic [3:0] rest;

    function automatic bb3_kind_t pick(input logic [3:0] p);
        bb3_kind_t k;
        priority if (p[0]) k = KIND_UP_LEFT;
        else if (p[1])     k = KIND_UP;
        else if (p[2])     k = KIND_LEFT;
        else               k = KIND_HERE;
        return k;
    endfunction

    // results still owed after the one being loaded
    assign rest = pend_reg & ~(4'b0001 << sel_reg);

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.take   = (state_reg == ST_IDLE);
    assign cmd.update = (state_reg == ST_UPDATE);
    assign cmd.sel    = sel_reg;
    assign cmd.load   = (state_reg == ST_LOAD) && stat.out_free;
    assign cmd.last   = (rest == 4'b0000);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 4'b0000;
            sel_reg   <= KIND_UP_LEFT;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    pend_reg <= stat.pend;
                    sel_reg  <= pick(stat.pend);
                    if (stat.pend != 4'b0000) begin
                        state_reg <= ST_SUM;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SUM: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (stat.out_free) begin
                        pend_reg <= rest;
                        sel_reg  <= pick(rest);
                        if (rest != 4'b0000) begin
                            state_reg <= ST_SUM;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `BB3_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> state_reg == ST_IDLE, "not idle after reset")
    `BB3_ASSERT(a_sel_pending, aclk, aresetn, (state_reg == ST_SUM || state_reg == ST_MUL || state_reg == ST_LOAD) |-> pend_reg[sel_reg], "working on a result that is not pending")
    `BB3_ASSERT(a_last_to_idle, aclk, aresetn, (cmd.load && cmd.last) |=> state_reg == ST_IDLE, "last result loaded but not idle")

endmodule

// ===== design/bb3_dpath.sv =====
// datapath: config, counters, line store, window, masked sum, divider, output register
`include "box_blur_3x3_edge_aware_macros.svh"
module bb3_dpath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    input  logic [bb3_pkg::PIX_W-1:0]         s_tdata,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [bb3_pkg::PIX_W-1:0]         m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser,
    input  bb3_pkg::bb3_cmd_t                 cmd,
    output bb3_pkg::bb3_stat_t                stat
);
    import bb3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
    localparam int HW = (RW + 1 > IMG_H_W) ? RW + 1 : IMG_H_W;
    localparam int P_W = X_W + M_W;
    localparam int R_W = Q0_W + D_W;

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic               m_tvalid_reg;
    logic [PIX_W-1:0]   m_tdata_reg;
    logic               m_tlast_reg;
    logic               m_tuser_reg;

    logic [WW-1:0] w_ext, w_eff, w_last;
    logic [HW-1:0] h_ext, h_eff, h_last;
    logic          c_last, r_last, c_ge1, r_ge1;

    // line store: upper row in the low half, middle row in the high half
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [PIX_W-1:0]   px_reg;
    logic [PIX_W-1:0]   win_reg [3][3];
    logic               pos_r_ge1_reg, pos_r_ge2_reg, pos_c_ge1_reg, pos_c_ge2_reg;

    logic [2:0]       row_inc, col_inc;
    logic [1:0]       nr, nc;
    logic [3:0]       n;
    logic [SUM_W-1:0] sum [3];
    logic [X_W-1:0]   x_reg [3];
    logic [D_W-1:0]   d_reg;
    logic [M_W-1:0]   m_reg;
    logic [P_W-1:0]   prod [3];
    logic [Q0_W-1:0]  q0_reg [3];
    logic [R_W-1:0]   rem [3];
    logic [Q0_W-1:0]  q [3];

    // effective frame size: zero means one, above the store size saturates
    always_comb begin
        w_ext = WW'(width_reg);
        h_ext = HW'(height_reg);
        priority if (w_ext == '0)                w_eff = WW'(1);
        else if (w_ext > WW'(MAX_WIDTH))         w_eff = WW'(MAX_WIDTH);
        else                                     w_eff = w_ext;
        priority if (h_ext == '0)                h_eff = HW'(1);
        else if (h_ext > HW'(MAX_HEIGHT))        h_eff = HW'(MAX_HEIGHT);
        else                                     h_eff = h_ext;
        w_last = w_eff - WW'(1);
        h_last = h_eff - HW'(1);
    end

    assign c_last = (WW'(col_reg) == w_last);
    assign r_last = (HW'(row_reg) == h_last);
    assign c_ge1  = (col_reg != '0);
    assign r_ge1  = (row_reg != '0);

    assign stat.pend[0]  = r_ge1 && c_ge1;
    assign stat.pend[1]  = r_ge1 && c_last;
    assign stat.pend[2]  = r_last && c_ge1;
    assign stat.pend[3]  = r_last && c_last;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_IMAGE_WIDTH) begin
                    width_reg <= cfg_wdata[IMG_W_W-1:0];
                    col_reg   <= '0;
                    row_reg   <= '0;
                end else if (cfg_index == REG_IMAGE_HEIGHT) begin
                    height_reg <= cfg_wdata[IMG_H_W-1:0];
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
            end else if (cmd.update) begin
                if (c_last) begin
                    col_reg <= '0;
                    if (r_last) begin
                        row_reg <= '0;
                    end else begin
                        row_reg <= row_reg + RW'(1);
                    end
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (cmd.load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // line store read every cycle, written on update (read sees the old entry)
    always_ff @(posedge aclk) begin
        rd_reg <= line_mem[col_reg];
        if (cmd.update) begin
            line_mem[col_reg] <= {px_reg, rd_reg[2*PIX_W-1:PIX_W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && s_tvalid) begin
            px_reg <= s_tdata;
        end
        if (cmd.update) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_reg[PIX_W-1:0];
            win_reg[1][2] <= rd_reg[2*PIX_W-1:PIX_W];
            win_reg[2][2] <= px_reg;
            pos_r_ge1_reg <= r_ge1;
            pos_r_ge2_reg <= (row_reg > RW'(1));
            pos_c_ge1_reg <= c_ge1;
            pos_c_ge2_reg <= (col_reg > CW'(1));
        end
    end

    // window rows/cols inside the frame and next to the selected center
    always_comb begin
        row_inc[0] = (cmd.sel == KIND_UP_LEFT || cmd.sel == KIND_UP) && pos_r_ge2_reg;
        row_inc[1] = pos_r_ge1_reg;
        row_inc[2] = 1'b1;
        col_inc[0] = (cmd.sel == KIND_UP_LEFT || cmd.sel == KIND_LEFT) && pos_c_ge2_reg;
        col_inc[1] = pos_c_ge1_reg;
        col_inc[2] = 1'b1;
        nr = 2'($countones(row_inc));
        nc = 2'($countones(col_inc));
        n  = 4'(nr) * 4'(nc);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (row_inc[i] && col_inc[j]) begin
                        sum[k] = sum[k] + SUM_W'(win_reg[i][j][k*CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    // rounded mean: floor((2*sum + n) / (2n)) by reciprocal, then one correction
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = P_W'(x_reg[k]) * P_W'(m_reg);
            rem[k]  = R_W'(x_reg[k]) - R_W'(q0_reg[k]) * R_W'(d_reg);
            q[k]    = q0_reg[k] + Q0_W'(rem[k] >= R_W'(d_reg));
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            x_reg[k]  <= {sum[k], 1'b0} + X_W'(n);
            q0_reg[k] <= prod[k][M_W +: Q0_W];
        end
        d_reg <= {n, 1'b0};
        m_reg <= bb3_recip(n);
        if (cmd.load) begin
            m_tdata_reg <= {q[2][CH_W-1:0], q[1][CH_W-1:0], q[0][CH_W-1:0]};
            m_tlast_reg <= cmd.last;
            m_tuser_reg <= (cmd.sel == KIND_HERE);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `BB3_ASSERT(a_col_in_frame, aclk, aresetn, WW'(col_reg) <= w_last, "column beyond frame width")
    `BB3_ASSERT(a_row_in_frame, aclk, aresetn, HW'(row_reg) <= h_last, "row beyond frame height")
    `BB3_ASSERT(a_load_free, aclk, aresetn, cmd.load |-> (!m_tvalid_reg || m_tready), "output overwritten before taken")

endmodule

// ===== design/box_blur_3x3_edge_aware.sv =====
// top level of the edge-aware 3x3 box blur
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: red, green, blue
//  m_        out  m_tvalid/m_tready  m_tdata: red, green, blue; m_tlast; m_tuser
//  cfg_      in   cfg_we             cfg_index, cfg_wdata (width, height)
//
// a pixel that owes no result goes through accept, then line store update
// each result then passes through the sum, multiply and load states of the one shared sum / reciprocal divider path
// results leave one at a time from an output register; m_tready low holds the last load
// aresetn is synchronous; the line store has no clearing pass, entries are used only
// after they are written in the current frame
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bb3_pkg::PIX_W-1:0]     s_tdata,   // in_red, in_green, in_blue
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bb3_pkg::PIX_W-1:0]     m_tdata,   // out_red, out_green, out_blue
    output logic                          m_tlast,
    output logic                          m_tuser    // end_of_frame
);
    import bb3_pkg::*;

    bb3_cmd_t  cmd;
    bb3_stat_t stat;

    bb3_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bb3_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
